/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files of the short I2C write engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/i2cmsw_pkg.sv */
// Package with the types and constants of the short I2C write engine.
package i2cmsw_pkg;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ST_SDA  = 4'd1,
        PH_ST_SCL  = 4'd2,
        PH_ST_LOW  = 4'd3,
        PH_LEAD    = 4'd4,
        PH_BIT_SDA = 4'd5,
        PH_BIT_HI  = 4'd6,
        PH_BIT_LO  = 4'd7,
        PH_ACK_LO  = 4'd8,
        PH_ACK_REL = 4'd9,
        PH_ACK_HI  = 4'd10,
        PH_ACK_SMP = 4'd11,
        PH_SP_SDA  = 4'd12,
        PH_SP_SCL0 = 4'd13,
        PH_SP_SCL1 = 4'd14,
        PH_SP_REL  = 4'd15
    } phase_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [2:0] status;
    } result_t;

    localparam logic       OP_TICK    = 1'b0;
    localparam logic       OP_START   = 1'b1;
    localparam logic       WRITE_BIT  = 1'b0;
    localparam logic [2:0] STATUS_OK  = 3'd0;
    localparam int         HELD_DEPTH = 4;

endpackage

/* rtl/i2c_master_short_write_core.sv */
// Top level of the short I2C write engine: handshake and registered result.
// Latency: the result of an item is valid in the cycle after the item is accepted.
// Throughput: one item per clock; the output register is reloaded in the same
// cycle that its item is taken, so input and output stall only together.
// Reset (asynchronous, active low): both engine lines released high, engine idle, no
// result pending, engine status zero; the result register itself is not reset.
`include "assert_macros.svh"

module i2c_master_short_write_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    input  logic [6:0] slave_address,
    input  logic [7:0] control_byte,
    input  logic [7:0] first_data,
    input  logic [7:0] second_data,
    input  logic [1:0] data_count,
    input  logic       sda_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       scl_level,
    output logic       sda_level,
    output logic       busy_res,
    output logic       done_res,
    output logic [2:0] status
);
    import i2cmsw_pkg::*;

    logic    accept;
    logic    out_valid_reg, out_valid_next;
    result_t result;
    result_t result_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    i2cmsw_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (accept),
        .op            (op),
        .slave_address (slave_address),
        .control_byte  (control_byte),
        .first_data    (first_data),
        .second_data   (second_data),
        .data_count    (data_count),
        .sda_in        (sda_in),
        .result        (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign scl_level = result_reg.scl;
    assign sda_level = result_reg.sda;
    assign busy_res  = result_reg.busy;
    assign done_res  = result_reg.done;
    assign status    = result_reg.status;

    `ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, out_valid_reg)
    `ASSERT_IMPLIES(a_done_not_busy, clk, rst_n, out_valid_reg && result_reg.done,
        !result_reg.busy)
    `ASSERT_IMPLIES(a_stall_blocks_input, clk, rst_n, out_valid_reg && !out_ready, !in_ready)

endmodule

/* rtl/i2cmsw_engine.sv */
// Line-step state machine of the short I2C write engine with its held bytes.
`include "assert_macros.svh"

module i2cmsw_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                op,
    input  logic [6:0]          slave_address,
    input  logic [7:0]          control_byte,
    input  logic [7:0]          first_data,
    input  logic [7:0]          second_data,
    input  logic [1:0]          data_count,
    input  logic                sda_in,
    output i2cmsw_pkg::result_t result
);
    import i2cmsw_pkg::*;

    phase_t     phase_reg, phase_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic [2:0] bit_index_reg, bit_index_next;
    logic [1:0] byte_index_reg, byte_index_next;
    logic [1:0] byte_total_reg, byte_total_next;
    logic [2:0] result_code_reg, result_code_next;
    logic [7:0] held_bytes_reg [HELD_DEPTH];

    logic       start_go;
    logic       tick_go;
    logic       nack;
    logic       last_byte;
    logic       tx_bit;
    logic [1:0] count_norm;

    assign start_go  = step && (op == OP_START) && (phase_reg == PH_IDLE);
    assign tick_go   = step && (op == OP_TICK) && (phase_reg != PH_IDLE);
    assign nack      = sda_in;
    assign last_byte = (byte_index_reg >= byte_total_reg);
    assign tx_bit    = held_bytes_reg[byte_index_reg][bit_index_reg];

    // A count of zero sends one data byte and a count of three sends two.
    always_comb
    begin
        if (data_count == 2'd0)
        begin
            count_norm = 2'd1;
        end
        else if (data_count == 2'd3)
        begin
            count_norm = 2'd2;
        end
        else
        begin
            count_norm = data_count;
        end
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (start_go)
        begin
            phase_next = PH_ST_SDA;
        end
        else if (tick_go)
        begin
            unique case (phase_reg)
                PH_ST_SDA:  phase_next = PH_ST_SCL;
                PH_ST_SCL:  phase_next = PH_ST_LOW;
                PH_ST_LOW:  phase_next = PH_LEAD;
                PH_LEAD:    phase_next = PH_BIT_SDA;
                PH_BIT_SDA: phase_next = PH_BIT_HI;
                PH_BIT_HI:  phase_next = PH_BIT_LO;
                PH_BIT_LO:  phase_next = (bit_index_reg == 3'd0) ? PH_ACK_LO : PH_BIT_SDA;
                PH_ACK_LO:  phase_next = PH_ACK_REL;
                PH_ACK_REL: phase_next = PH_ACK_HI;
                PH_ACK_HI:  phase_next = PH_ACK_SMP;
                PH_ACK_SMP: phase_next = (nack || last_byte) ? PH_SP_SDA : PH_LEAD;
                PH_SP_SDA:  phase_next = PH_SP_SCL0;
                PH_SP_SCL0: phase_next = PH_SP_SCL1;
                PH_SP_SCL1: phase_next = PH_SP_REL;
                PH_SP_REL:  phase_next = PH_IDLE;
                default:    phase_next = phase_reg;
            endcase
        end
    end

    // Line levels, counters and the result code.
    always_comb
    begin
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        bit_index_next   = bit_index_reg;
        byte_index_next  = byte_index_reg;
        byte_total_next  = byte_total_reg;
        result_code_next = result_code_reg;
        if (start_go)
        begin
            byte_total_next  = count_norm + 2'd1;
            byte_index_next  = 2'd0;
            bit_index_next   = 3'd0;
            result_code_next = STATUS_OK;
        end
        else if (tick_go)
        begin
            unique case (phase_reg)
                PH_ST_SDA:  sda_next = 1'b1;
                PH_ST_SCL:  scl_next = 1'b1;
                PH_ST_LOW:  sda_next = 1'b0;
                PH_LEAD:
                begin
                    scl_next       = 1'b0;
                    bit_index_next = 3'd7;
                end
                PH_BIT_SDA: sda_next = tx_bit;
                PH_BIT_HI:  scl_next = 1'b1;
                PH_BIT_LO:
                begin
                    scl_next = 1'b0;
                    if (bit_index_reg != 3'd0)
                    begin
                        bit_index_next = bit_index_reg - 3'd1;
                    end
                end
                PH_ACK_LO:  scl_next = 1'b0;
                PH_ACK_REL: sda_next = 1'b1;
                PH_ACK_HI:  scl_next = 1'b1;
                PH_ACK_SMP:
                begin
                    scl_next = 1'b0;
                    if (nack)
                    begin
                        // The code names the failed byte: address is one, and so on.
                        result_code_next = {1'b0, byte_index_reg} + 3'd1;
                    end
                    else if (last_byte)
                    begin
                        result_code_next = STATUS_OK;
                    end
                    else
                    begin
                        byte_index_next = byte_index_reg + 2'd1;
                    end
                end
                PH_SP_SDA:  sda_next = 1'b0;
                PH_SP_SCL0: scl_next = 1'b0;
                PH_SP_SCL1: scl_next = 1'b1;
                PH_SP_REL:  sda_next = 1'b1;
                default:    scl_next = scl_reg;
            endcase
        end
    end

    // Result of this item, taken from the updated state.
    always_comb
    begin
        result.scl    = scl_next;
        result.sda    = sda_next;
        result.busy   = (phase_next != PH_IDLE);
        result.done   = tick_go && (phase_reg == PH_SP_REL);
        result.status = result_code_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            bit_index_reg   <= 3'd0;
            byte_index_reg  <= 2'd0;
            byte_total_reg  <= 2'd0;
            result_code_reg <= STATUS_OK;
        end
        else
        begin
            phase_reg       <= phase_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            bit_index_reg   <= bit_index_next;
            byte_index_reg  <= byte_index_next;
            byte_total_reg  <= byte_total_next;
            result_code_reg <= result_code_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_go)
        begin
            held_bytes_reg[0] <= {slave_address, WRITE_BIT};
            held_bytes_reg[1] <= control_byte;
            held_bytes_reg[2] <= first_data;
            held_bytes_reg[3] <= second_data;
        end
    end

    `ASSERT_NEXT(a_start_enters_sequence, clk, rst_n, start_go, phase_reg == PH_ST_SDA)
    `ASSERT_NEXT(a_stop_releases_lines, clk, rst_n, tick_go && (phase_reg == PH_SP_REL),
        (phase_reg == PH_IDLE) && sda_reg && scl_reg)
    `ASSERT_NEXT(a_bit_countdown, clk, rst_n,
        tick_go && (phase_reg == PH_BIT_LO) && (bit_index_reg != 3'd0),
        bit_index_reg == 3'($past(bit_index_reg) - 3'd1))
    `ASSERT_NEXT(a_idle_without_step, clk, rst_n, !step, $stable(phase_reg))

endmodule

/* verif/i2cmsw_line_checker.sv */
// Checker that predicts every line step of the short I2C write engine and compares results.
module i2cmsw_line_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       op,
    input  logic [6:0] slave_address,
    input  logic [7:0] control_byte,
    input  logic [7:0] first_data,
    input  logic [7:0] second_data,
    input  logic [1:0] data_count,
    input  logic       sda_in,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       scl_level,
    input  logic       sda_level,
    input  logic       busy_res,
    input  logic       done_res,
    input  logic [2:0] status,
    output int         mismatches,
    output int         outstanding
);
    import i2cmsw_pkg::*;

    result_t    expected_lines[$];
    logic       scl_q;
    logic       sda_q;
    phase_t     phase_q;
    logic [3:0] bit_pos;
    logic [1:0] byte_pos;
    logic [7:0] wire_bytes [HELD_DEPTH];
    logic [1:0] last_byte;
    logic [2:0] code_q;

    task automatic step_line_engine(input logic o, input logic [6:0] a, input logic [7:0] c,
                                    input logic [7:0] d1, input logic [7:0] d2,
                                    input logic [1:0] cnt, input logic sd,
                                    output result_t r);
        logic       finished;
        logic [1:0] eff;
        finished = 1'b0;
        if (o == OP_START) begin
            // A start while a transfer runs leaves everything untouched.
            if (phase_q == PH_IDLE) begin
                wire_bytes[0] = {a, WRITE_BIT};
                wire_bytes[1] = c;
                wire_bytes[2] = d1;
                wire_bytes[3] = d2;
                eff = cnt;
                if (eff == 2'd0)
                    eff = 2'd1;
                else if (eff == 2'd3)
                    eff = 2'd2;
                last_byte = eff + 2'd1;
                byte_pos  = 2'd0;
                bit_pos   = 4'd0;
                code_q    = STATUS_OK;
                phase_q   = PH_ST_SDA;
            end
        end
        else begin
            case (phase_q)
                PH_ST_SDA:
                begin
                    sda_q = 1'b1;
                    phase_q = PH_ST_SCL;
                end
                PH_ST_SCL:
                begin
                    scl_q = 1'b1;
                    phase_q = PH_ST_LOW;
                end
                PH_ST_LOW:
                begin
                    sda_q = 1'b0;
                    phase_q = PH_LEAD;
                end
                PH_LEAD:
                begin
                    scl_q = 1'b0;
                    bit_pos = 4'd7;
                    phase_q = PH_BIT_SDA;
                end
                PH_BIT_SDA:
                begin
                    sda_q = wire_bytes[byte_pos][bit_pos[2:0]];
                    phase_q = PH_BIT_HI;
                end
                PH_BIT_HI:
                begin
                    scl_q = 1'b1;
                    phase_q = PH_BIT_LO;
                end
                PH_BIT_LO:
                begin
                    scl_q = 1'b0;
                    if (bit_pos == 4'd0)
                        phase_q = PH_ACK_LO;
                    else
                    begin
                        bit_pos = bit_pos - 4'd1;
                        phase_q = PH_BIT_SDA;
                    end
                end
                PH_ACK_LO:
                begin
                    scl_q = 1'b0;
                    phase_q = PH_ACK_REL;
                end
                PH_ACK_REL:
                begin
                    sda_q = 1'b1;
                    phase_q = PH_ACK_HI;
                end
                PH_ACK_HI:
                begin
                    scl_q = 1'b1;
                    phase_q = PH_ACK_SMP;
                end
                PH_ACK_SMP:
                begin
                    scl_q = 1'b0;
                    // A NACK reports the failing byte as its index plus one.
                    if (sd) begin
                        code_q = {1'b0, byte_pos} + 3'd1;
                        phase_q = PH_SP_SDA;
                    end
                    else if (byte_pos >= last_byte) begin
                        code_q = STATUS_OK;
                        phase_q = PH_SP_SDA;
                    end
                    else begin
                        byte_pos = byte_pos + 2'd1;
                        phase_q = PH_LEAD;
                    end
                end
                PH_SP_SDA:
                begin
                    sda_q = 1'b0;
                    phase_q = PH_SP_SCL0;
                end
                PH_SP_SCL0:
                begin
                    scl_q = 1'b0;
                    phase_q = PH_SP_SCL1;
                end
                PH_SP_SCL1:
                begin
                    scl_q = 1'b1;
                    phase_q = PH_SP_REL;
                end
                PH_SP_REL:
                begin
                    sda_q = 1'b1;
                    phase_q = PH_IDLE;
                    finished = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        r.scl    = scl_q;
        r.sda    = sda_q;
        r.busy   = (phase_q != PH_IDLE);
        r.done   = finished;
        r.status = code_q;
    endtask

    task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        result_t next_line;
        if (!rst_n) begin
            scl_q    = 1'b1;
            sda_q    = 1'b1;
            phase_q  = PH_IDLE;
            bit_pos  = 4'd0;
            byte_pos = 2'd0;
            for (int i = 0; i < HELD_DEPTH; i++)
                wire_bytes[i] = 8'd0;
            last_byte = 2'd0;
            code_q    = STATUS_OK;
            expected_lines.delete();
            outstanding <= 0;
        end
        else begin
            // Compare first: a result taken now always belongs to an earlier item.
            if (out_valid && out_ready) begin
                if (expected_lines.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no item waiting, actual scl=%0b sda=%0b", $time,
                             scl_level, sda_level);
                end
                else begin
                    want = expected_lines.pop_front();
                    check_field("scl_level", want.scl, scl_level);
                    check_field("sda_level", want.sda, sda_level);
                    check_field("busy_res", want.busy, busy_res);
                    check_field("done_res", want.done, done_res);
                    check_field("status", want.status, status);
                end
            end
            if (in_valid && in_ready) begin
                step_line_engine(op, slave_address, control_byte, first_data, second_data,
                                 data_count, sda_in, next_line);
                expected_lines.push_back(next_line);
            end
            outstanding <= expected_lines.size();
        end
    end

endmodule

/* verif/tb_i2c_master_short_write_core.sv */
// Testbench top for the short I2C write engine: stimulus, receiver stalls and verdict.
module tb_i2c_master_short_write_core;
    import i2cmsw_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_TARGET  = 1400;

    logic       clk;
    logic       rst_n         = 1'b1;
    logic       in_valid      = 1'b0;
    logic       in_ready;
    logic       op            = OP_TICK;
    logic [6:0] slave_address = 7'd0;
    logic [7:0] control_byte  = 8'd0;
    logic [7:0] first_data    = 8'd0;
    logic [7:0] second_data   = 8'd0;
    logic [1:0] data_count    = 2'd0;
    logic       sda_in        = 1'b0;
    logic       out_valid;
    logic       out_ready     = 1'b0;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
    int         mismatches;
    int         outstanding;

    logic       hold_req    = 1'b0;
    int         burst_left  = 0;
    int         useful_items = 0;
    int         cycle_count = 0;

    i2c_master_short_write_core u_top (.*);

    i2cmsw_line_checker u_checker (.*);

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: stretches of steady, random or sparse acceptance, plus long hold-offs on request.
    initial begin : receiver
        int mode;
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(8, 80)) begin
                @(posedge clk);
                if (hold_req) begin
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_req = 1'b0;
                end
                else if (mode == 0)
                    out_ready <= 1'b1;
                else if (mode == 1)
                    out_ready <= 1'($urandom_range(0, 1));
                else
                    out_ready <= ($urandom_range(0, 5) == 0);
            end
        end
    end

    task automatic send_item(input logic o, input logic [6:0] a, input logic [7:0] c,
                             input logic [7:0] d1, input logic [7:0] d2,
                             input logic [1:0] cnt, input logic sd);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 20);
        end
        op            <= o;
        slave_address <= a;
        control_byte  <= c;
        first_data    <= d1;
        second_data   <= d2;
        data_count    <= cnt;
        sda_in        <= sd;
        in_valid      <= 1'b1;
        burst_left--;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_tick(input logic sd);
        send_item(OP_TICK, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  2'($urandom), sd);
    endtask

    // One write transfer: a start, then exactly the ticks it takes to reach the stop,
    // with the ACK level chosen per byte and a stray start now and then.
    task automatic run_write(input logic [6:0] a, input logic [7:0] c, input logic [7:0] d1,
                             input logic [7:0] d2, input logic [1:0] cnt, input int nack_byte);
        int   last_sent;
        int   n_ticks;
        logic sd;
        last_sent = (cnt == 2'd0 || cnt == 2'd1) ? 2 : 3;
        if (nack_byte >= 0 && nack_byte < last_sent)
            last_sent = nack_byte;
        n_ticks = 3 + 29 * (last_sent + 1) + 4;
        send_item(OP_START, a, c, d1, d2, cnt, 1'($urandom_range(0, 1)));
        useful_items++;
        for (int t = 1; t <= n_ticks; t++) begin
            if ($urandom_range(0, 24) == 0)
                send_item(OP_START, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          2'($urandom), 1'($urandom_range(0, 1)));
            sd = 1'($urandom_range(0, 1));
            // The last tick of each ACK slot is where the level is sampled.
            if (t > 3 && (t - 3) % 29 == 0)
                sd = ((t - 3) / 29 - 1 == nack_byte);
            send_tick(sd);
            useful_items++;
        end
    endtask

    initial begin : stimulus
        int tx;
        int nack;
        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Ticks while idle, field extremes, both clamped counts and a NACK on every byte.
        send_tick(1'b0);
        send_tick(1'b1);
        run_write(7'h00, 8'h00, 8'h00, 8'h00, 2'd0, -1);
        run_write(7'h7F, 8'hFF, 8'hFF, 8'hFF, 2'd3, -1);
        for (int k = 0; k < 4; k++)
            run_write(7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 2'd2, k);
        run_write(7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 2'd1, 2);

        tx = 0;
        while (useful_items < ITEM_TARGET) begin
            nack = ($urandom_range(0, 9) < 4) ? -1 : $urandom_range(0, 3);
            if (tx % 6 == 2)
                hold_req = 1'b1;
            if (tx % 6 == 4) begin
                in_valid <= 1'b0;
                @(posedge clk);
                wait (outstanding == 0);
                @(posedge clk);
            end
            run_write(7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
                      nack);
            repeat ($urandom_range(0, 2))
                send_tick(1'($urandom_range(0, 1)));
            tx++;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
